// ===== rtl/core/fdl_pkg.sv =====
`timescale 1ns / 1ps

package fdl_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_FIND_NAME = 2'd1;
    localparam logic [1:0] OP_FIND_ADDR = 2'd2;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SORTED_BY_NAME = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  entry_index;
        logic [31:0] entry_address;
        logic [31:0] entry_size;
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic [31:0] lookup_address;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] file_address;
        logic [31:0] file_size;
        logic [63:0] found_name_high;
        logic [63:0] found_name_low;
    } out_item_t;

    typedef enum logic [1:0] {
        RES_ACK,
        RES_MISS,
        RES_HIT
    } res_kind_t;

    typedef struct packed {
        logic      load_query;
        logic      write_entry;
        logic      init_search;
        logic      issue_read;
        logic      step;
        logic      load_result;
        res_kind_t kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_ok;
        logic       hit;
        logic       more;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/fdl_ram.sv =====
`timescale 1ns / 1ps

module fdl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fdl_datapath.sv =====
`timescale 1ns / 1ps

module fdl_datapath #(
    parameter int unsigned MAX_ENTRIES  = 64,
    parameter int unsigned NAME_BYTES   = 16,
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  fdl_pkg::in_item_t                  s_data,
    input  fdl_pkg::ctrl_cmd_t                 cmd,
    output fdl_pkg::dp_status_t                status,
    input  logic                               m_ready,
    output logic                               m_valid,
    output fdl_pkg::out_item_t                 m_data
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned PW    = IDX_W + 1;
    localparam int unsigned AW    = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int unsigned RAM_W = AW + 32 + 128;
    localparam logic [63:0] HI_MASK = (NAME_BYTES >= 8) ? {64{1'b1}}
                                    : ({64{1'b1}} << (8 * (8 - NAME_BYTES)));
    localparam logic [63:0] LO_MASK = (NAME_BYTES <= 8) ? 64'd0
                                    : (NAME_BYTES >= 16) ? {64{1'b1}}
                                    : ({64{1'b1}} << (8 * (16 - NAME_BYTES)));

    // configuration
    logic                        sorted_reg;
    logic [fdl_pkg::CFG_DATA_W-1:0] count_reg;

    // latched item
    logic [1:0]    op_reg;
    logic [5:0]    slot_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [31:0]   wr_size_reg;
    logic [63:0]   qh_reg;
    logic [63:0]   ql_reg;
    logic [AW-1:0] qa_reg;

    // search window
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] hi_reg, hi_next;

    // result register
    logic               m_valid_reg;
    fdl_pkg::out_item_t m_data_reg, m_data_next;

    logic             by_name, binary, slot_ok;
    logic [PW-1:0]    mid_sum, lo_inc, lin_inc, hi_dec;
    logic [IDX_W-1:0] mid, probe;
    logic [RAM_W-1:0] rd_data, wr_data;
    logic [AW-1:0]    ent_addr;
    logic [31:0]      ent_size;
    logic [63:0]      ent_nh, ent_nl;
    logic             cmp_lt, cmp_eq, more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sorted_reg <= 1'b0;
            count_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fdl_pkg::CFG_SORTED_BY_NAME: sorted_reg <= cfg_wr_data[0];
                fdl_pkg::CFG_ENTRY_COUNT:    count_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            op_reg      <= s_data.operation;
            slot_reg    <= s_data.entry_index;
            wr_addr_reg <= s_data.entry_address[AW-1:0];
            wr_size_reg <= s_data.entry_size;
            qh_reg      <= s_data.name_high & HI_MASK;
            ql_reg      <= s_data.name_low & LO_MASK;
            qa_reg      <= s_data.lookup_address[AW-1:0];
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign by_name = (op_reg == fdl_pkg::OP_FIND_NAME);
    assign binary  = by_name ? sorted_reg : !sorted_reg;
    assign slot_ok = (32'(slot_reg) < 32'(MAX_ENTRIES));

    // probe slot: midpoint for a binary search, low edge for a scan
    assign mid_sum = lo_reg + hi_reg;
    assign mid     = mid_sum[PW-1:1];
    assign probe   = binary ? mid : lo_reg[IDX_W-1:0];

    assign wr_data = {wr_addr_reg, wr_size_reg, qh_reg, ql_reg};

    fdl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.write_entry && slot_ok),
        .wr_addr (IDX_W'(slot_reg)),
        .wr_data (wr_data),
        .rd_en   (cmd.issue_read),
        .rd_addr (probe),
        .rd_data (rd_data)
    );

    assign ent_addr = rd_data[RAM_W-1:160];
    assign ent_size = rd_data[159:128];
    assign ent_nh   = rd_data[127:64];
    assign ent_nl   = rd_data[63:0];

    always_comb begin
        if (by_name) begin
            cmp_lt = ({ent_nh, ent_nl} < {qh_reg, ql_reg});
            cmp_eq = ({ent_nh, ent_nl} == {qh_reg, ql_reg});
        end else begin
            cmp_lt = (ent_addr < qa_reg);
            cmp_eq = (ent_addr == qa_reg);
        end
    end

    assign lo_inc  = PW'(mid) + PW'(1);
    assign hi_dec  = PW'(mid) - PW'(1);
    assign lin_inc = lo_reg + PW'(1);

    // window setup at search start, and update after a probe that did not match
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        more    = 1'b0;
        if (cmd.init_search) begin
            lo_next = '0;
            hi_next = PW'(count_reg - 7'd1);
        end else if (binary) begin
            if (cmp_lt) begin
                more = (lo_inc <= hi_reg);
                if (cmd.step) lo_next = lo_inc;
            end else if (mid != '0) begin
                more = (lo_reg <= hi_dec);
                if (cmd.step) hi_next = hi_dec;
            end
        end else begin
            more = (lin_inc <= hi_reg);
            if (cmd.step) lo_next = lin_inc;
        end
    end

    always_comb begin
        m_data_next = '0;
        case (cmd.kind)
            fdl_pkg::RES_ACK: begin
                m_data_next.found = 1'b1;
            end
            fdl_pkg::RES_HIT: begin
                m_data_next.found           = 1'b1;
                m_data_next.file_address    = 32'(ent_addr);
                m_data_next.file_size       = ent_size;
                m_data_next.found_name_high = ent_nh;
                m_data_next.found_name_low  = ent_nl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_result) begin
            m_data_reg <= m_data_next;
        end
    end

    assign status.op       = op_reg;
    assign status.count_ok = (count_reg != '0) && (32'(count_reg) <= 32'(MAX_ENTRIES));
    assign status.hit      = cmp_eq;
    assign status.more     = more;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/fdl_ctrl.sv =====
`timescale 1ns / 1ps

module fdl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fdl_pkg::dp_status_t status,
    output fdl_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    fdl_pkg::res_kind_t  kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= fdl_pkg::RES_MISS;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.kind   = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_query = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.op)
                    fdl_pkg::OP_WRITE: begin
                        cmd.write_entry = 1'b1;
                        kind_next       = fdl_pkg::RES_ACK;
                        state_next      = ST_DONE;
                    end
                    fdl_pkg::OP_FIND_NAME, fdl_pkg::OP_FIND_ADDR: begin
                        if (status.count_ok) begin
                            cmd.init_search = 1'b1;
                            state_next      = ST_READ;
                        end else begin
                            kind_next  = fdl_pkg::RES_MISS;
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        kind_next  = fdl_pkg::RES_MISS;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                cmd.issue_read = 1'b1;
                state_next     = ST_CMP;
            end
            ST_CMP: begin
                if (status.hit) begin
                    kind_next  = fdl_pkg::RES_HIT;
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                    if (status.more) begin
                        state_next = ST_READ;
                    end else begin
                        kind_next  = fdl_pkg::RES_MISS;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/file_directory_lookup_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  fdl_pkg::in_item_t  (write, name query, address query)
// m_        out  m_valid / m_ready  fdl_pkg::out_item_t (one result item per input item)
// cfg_      in   cfg_wr_en          cfg_index, cfg_wr_data (no read-back)
//
// One item at a time. Write item or unused code: accept, dispatch, then load the result.
// Query: accept, dispatch, P probes of the entry RAM (read, then compare), then result;
//   binary search P <= log2(count)+1, linear scan P <= count.
// Reset (aresetn low, synchronous) clears config and control; entries are not cleared.
// A result waiting in the output register does not block the next accept; a new
//   result waits in its final state until the output register frees up.

module file_directory_lookup_top #(
    parameter int unsigned MAX_ENTRIES  = 64,
    parameter int unsigned NAME_BYTES   = 16,
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fdl_pkg::in_item_t               s_data,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output fdl_pkg::out_item_t              m_data
);

    // controller <-> datapath
    fdl_pkg::ctrl_cmd_t  cmd;
    fdl_pkg::dp_status_t status;

    // sequencer: dispatch on opcode, walk probes, hand over the result
    fdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // config regs, item latch, search window, entry RAM, output register
    fdl_datapath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .NAME_BYTES   (NAME_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

// ===== rtl/core/fdl_checker.sv =====
`timescale 1ns / 1ps

module fdl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input fdl_pkg::out_item_t m_data
);

    // items accepted but not yet delivered
    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result item with no item outstanding");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two items in flight");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted an item while one is in progress");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |->
            m_data.file_address == 32'd0 && m_data.file_size == 32'd0 &&
            m_data.found_name_high == 64'd0 && m_data.found_name_low == 64'd0)
        else $error("miss result carries data");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

endmodule

bind file_directory_lookup_top fdl_checker u_fdl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
